// ----- src/tws_pkg.sv -----
// ----------------------------------------------------------------------------
// tws_pkg
// Widths, constants and stage types shared by the two-way ranging solver.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int STAMP_BITS      = 40;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int SCW  = 24;                  // scale register width
  localparam int GW   = 41;                  // final gap width
  localparam int RW   = 32;                  // range width
  localparam logic [SCW-1:0] SCALE_RESET = SCW'(307479);

  localparam int MW   = STAMP_BITS;          // magnitude of one difference
  localparam int DW   = STAMP_BITS + 1;      // magnitude of a difference of sums
  localparam int HB   = MW / 2;              // low split of a 40x40 product
  localparam int PW   = 2 * MW;              // product magnitude
  localparam int NW   = PW + 1;              // numerator magnitude
  localparam int SLO  = (DW + 1) / 2;        // low split for single-sided product
  localparam int SPW  = DW + SCW;            // single-sided product width
  localparam int SHW  = SPW - SCALE_FRAC_BITS;
  localparam int NCH  = 27;                  // numerator chunk for scaling
  localparam int NK   = (NW + NCH - 1) / NCH;
  localparam int NPAD = NK * NCH;
  localparam int NUMW = NW + SCW + 2;        // rounded dividend width
  localparam int DENW = DW + SCALE_FRAC_BITS + 1;
  localparam int QB   = RW;                  // quotient bits before overflow
  localparam int HIW  = NUMW - QB;

  typedef struct packed {
    logic [NW-1:0]   nmag;
    logic            nneg;
    logic [DW-1:0]   dm;
    logic            dneg;
    logic [GW-1:0]   gap;
    logic [RW-1:0]   single;
  } front_t;

  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [DENW-1:0] den;
    logic [QB-1:0]   lo;
    logic [QB-1:0]   q;
    logic            ovf;
    logic            neg;
    logic            fault;
    logic [GW-1:0]   gap;
    logic [RW-1:0]   single;
  } div_t;

endpackage

// ----- src/tws_front.sv -----
// ----------------------------------------------------------------------------
// tws_front
// Stamp differences, split products, single-sided range and signed numerator.
// ----------------------------------------------------------------------------
module tws_front
  import tws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [STAMP_BITS-1:0] poll_sent,
  input  logic [STAMP_BITS-1:0] poll_received,
  input  logic [STAMP_BITS-1:0] reply_sent,
  input  logic [STAMP_BITS-1:0] reply_received,
  input  logic [STAMP_BITS-1:0] final_sent,
  input  logic [STAMP_BITS-1:0] final_received,
  input  logic [SCW-1:0]        scale,
  output logic                  out_valid,
  output front_t                out_data
);

  // stage 1: differences
  logic            v1;
  logic [MW-1:0]   m0, m1, r0, r1;
  logic            s0, s1, q0, q1;
  logic [DW-1:0]   ym, dm1;
  logic            yn, dn1;
  logic [GW-1:0]   gap1;

  logic [DW-1:0]   sa, sb, da, db;

  always_comb begin
    sa = DW'(final_received) + DW'(reply_received);
    sb = DW'(reply_sent) + DW'(final_sent);
    da = DW'(final_sent) + DW'(final_received);
    db = DW'(poll_sent) + DW'(poll_received);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0   <= reply_received < poll_sent;
      m0   <= (reply_received < poll_sent) ? poll_sent - reply_received
                                           : reply_received - poll_sent;
      s1   <= final_received < reply_sent;
      m1   <= (final_received < reply_sent) ? reply_sent - final_received
                                            : final_received - reply_sent;
      q0   <= reply_sent < poll_received;
      r0   <= (reply_sent < poll_received) ? poll_received - reply_sent
                                           : reply_sent - poll_received;
      q1   <= final_sent < reply_received;
      r1   <= (final_sent < reply_received) ? reply_received - final_sent
                                            : final_sent - reply_received;
      yn   <= sa < sb;
      ym   <= (sa < sb) ? sb - sa : sa - sb;
      dn1  <= da < db;
      dm1  <= (da < db) ? db - da : da - db;
      gap1 <= GW'($signed({1'b0, final_received}) - $signed({1'b0, final_sent}));
    end
  end

  // stage 2: partial products
  logic                   v2;
  logic [MW+HB-1:0]       pm_lo, pr_lo;
  logic [2*MW-HB-1:0]     pm_hi, pr_hi;
  logic [SLO+SCW-1:0]     ys_lo;
  logic [DW-SLO+SCW-1:0]  ys_hi;
  logic                   sp2, sq2, yn2, dn2;
  logic [DW-1:0]          dm2;
  logic [GW-1:0]          gap2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_lo <= m0 * m1[HB-1:0];
      pm_hi <= m0 * m1[MW-1:HB];
      pr_lo <= r0 * r1[HB-1:0];
      pr_hi <= r0 * r1[MW-1:HB];
      ys_lo <= ym[SLO-1:0] * scale;
      ys_hi <= ym[DW-1:SLO] * scale;
      sp2   <= s0 ^ s1;
      sq2   <= q0 == q1;   // sign of the subtracted reply product
      yn2   <= yn;
      dn2   <= dn1;
      dm2   <= dm1;
      gap2  <= gap1;
    end
  end

  // stage 3: full products, rounded single-sided value
  logic              v3;
  logic [PW-1:0]     p3, q3;
  logic [SHW-1:0]    sh3;
  logic              sp3, sq3, yn3, dn3;
  logic [DW-1:0]     dm3;
  logic [GW-1:0]     gap3;
  logic [SPW:0]      ps;

  always_comb begin
    ps = (SPW+1)'(ys_lo) + ((SPW+1)'(ys_hi) << SLO)
       + ((SPW+1)'(1) << SCALE_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3   <= PW'(pm_lo) + (PW'(pm_hi) << HB);
      q3   <= PW'(pr_lo) + (PW'(pr_hi) << HB);
      sh3  <= ps[SPW:SCALE_FRAC_BITS+1];
      sp3  <= sp2;
      sq3  <= sq2;
      yn3  <= yn2;
      dn3  <= dn2;
      dm3  <= dm2;
      gap3 <= gap2;
    end
  end

  // stage 4: signed numerator, saturated single-sided range
  logic [SHW-1:0] lim_s, v_s;
  logic [NW-1:0]  n_next;
  logic           nn_next;

  always_comb begin
    lim_s = yn3 ? SHW'(33'h080000000) : SHW'(33'h07fffffff);
    v_s   = (sh3 > lim_s) ? lim_s : sh3;
    if (sp3 == sq3) begin
      n_next  = NW'(p3) + NW'(q3);
      nn_next = sp3;
    end else if (p3 >= q3) begin
      n_next  = NW'(p3 - q3);
      nn_next = sp3;
    end else begin
      n_next  = NW'(q3 - p3);
      nn_next = sq3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.nmag   <= n_next;
      out_data.nneg   <= nn_next;
      out_data.dm     <= dm3;
      out_data.dneg   <= dn3;
      out_data.gap    <= gap3;
      out_data.single <= yn3 ? RW'(-v_s) : RW'(v_s);
    end
  end

endmodule

// ----- src/tws_scale.sv -----
// ----------------------------------------------------------------------------
// tws_scale
// Scales the numerator in chunks, adds the rounding half and sets up division.
// ----------------------------------------------------------------------------
module tws_scale
  import tws_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  front_t         in_data,
  input  logic [SCW-1:0] scale,
  output logic           out_valid,
  output div_t           out_data
);

  // stage 5: chunk products
  logic                  v5;
  logic [NCH+SCW-1:0]    pp [NK];
  logic [NPAD-1:0]       nz;
  logic                  neg5;
  logic [DW-1:0]         dm5;
  logic [GW-1:0]         gap5;
  logic [RW-1:0]         single5;

  assign nz = NPAD'(in_data.nmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NK; k++) begin
        pp[k] <= nz[k*NCH +: NCH] * scale;
      end
      neg5    <= in_data.nneg ^ in_data.dneg;
      dm5     <= in_data.dm;
      gap5    <= in_data.gap;
      single5 <= in_data.single;
    end
  end

  // stage 6: dividend 2*n*scale + dm*2^F, divisor dm*2^(F+1)
  logic              v6;
  logic [NUMW-1:0]   num6;
  logic [DENW-1:0]   den6;
  logic              neg6, fault6;
  logic [GW-1:0]     gap6;
  logic [RW-1:0]     single6;
  logic [NUMW-1:0]   acc;

  always_comb begin
    acc = '0;
    for (int k = 0; k < NK; k++) begin
      acc = acc + (NUMW'(pp[k]) << (k * NCH));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num6    <= (acc << 1) + (NUMW'(dm5) << SCALE_FRAC_BITS);
      den6    <= DENW'(dm5) << (SCALE_FRAC_BITS + 1);
      fault6  <= dm5 == '0;
      neg6    <= neg5;
      gap6    <= gap5;
      single6 <= single5;
    end
  end

  // stage 7: overflow check on the top of the dividend
  logic [HIW-1:0] num_hi;

  assign num_hi = num6[NUMW-1:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.rem    <= num_hi[DENW-1:0];
      out_data.den    <= den6;
      out_data.lo     <= num6[QB-1:0];
      out_data.q      <= '0;
      out_data.ovf    <= num_hi >= HIW'(den6);
      out_data.neg    <= neg6;
      out_data.fault  <= fault6;
      out_data.gap    <= gap6;
      out_data.single <= single6;
    end
  end

endmodule

// ----- src/tws_div.sv -----
// ----------------------------------------------------------------------------
// tws_div
// Pipelined restoring divider, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module tws_div
  import tws_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  div_t          in_data,
  output logic          out_valid,
  output logic [GW-1:0] final_gap,
  output logic [RW-1:0] single_range_mm,
  output logic [RW-1:0] two_way_range_mm,
  output logic          divide_fault
);

  div_t stg [QB+1];
  logic vld [QB+1];

  assign stg[0] = in_data;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [DENW:0] r2;
    logic          ge;
    div_t          nxt;

    always_comb begin
      r2            = {stg[i].rem, stg[i].lo[QB-1-i]};
      ge            = r2 >= {1'b0, stg[i].den};
      nxt           = stg[i];
      nxt.rem       = ge ? DENW'(r2 - {1'b0, stg[i].den}) : DENW'(r2);
      nxt.q[QB-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[i+1] <= nxt;
      end
    end
  end

  // saturation and output register
  div_t          f;
  logic [QB-1:0] lim, v;

  always_comb begin
    f   = stg[QB];
    lim = f.neg ? QB'(33'h080000000) : QB'(33'h07fffffff);
    v   = (f.ovf || f.q > lim) ? lim : f.q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      final_gap        <= f.gap;
      single_range_mm  <= f.single;
      divide_fault     <= f.fault;
      if (f.fault) begin
        two_way_range_mm <= '0;
      end else begin
        two_way_range_mm <= f.neg ? RW'(-v) : RW'(v);
      end
    end
  end

endmodule

// ----- src/two_way_ranging_solver_core.sv -----
// ----------------------------------------------------------------------------
// two_way_ranging_solver_core
// Asymmetric double-sided two-way ranging from six 40-bit radio timestamps.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid / in_stall carries one exchange per request:
//   six timestamps in ticks. output channel out_valid / out_stall returns
//   the final gap, the single-sided range, the double-sided range and a
//   fault flag for a zero sum of round and reply times.
//   the scale register is written through cfg_valid / cfg_ready / cfg_data
//   (cfg_ready is always high); write it only while no request is in flight.
//   the pipeline holds 4 front stages (differences, split products, sums,
//   numerator), 3 scaling stages, 32 divider stages at one quotient bit
//   each and one output register.
//   throughput is one request per cycle while out_stall does not hold a
//   waiting result, set by the fully pipelined multipliers and divider.
//   when out_stall holds a waiting result, the whole pipeline freezes and
//   in_stall is raised; nothing is dropped or repeated.
//   synchronous reset empties the pipeline and loads the scale with its
//   default of 307479.
// ----------------------------------------------------------------------------
module two_way_ranging_solver_core
  import tws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SCW-1:0]        cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [STAMP_BITS-1:0] poll_sent,
  input  logic [STAMP_BITS-1:0] poll_received,
  input  logic [STAMP_BITS-1:0] reply_sent,
  input  logic [STAMP_BITS-1:0] reply_received,
  input  logic [STAMP_BITS-1:0] final_sent,
  input  logic [STAMP_BITS-1:0] final_received,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [GW-1:0]         final_gap,
  output logic [RW-1:0]         single_range_mm,
  output logic [RW-1:0]         two_way_range_mm,
  output logic                  divide_fault
);

  logic [SCW-1:0] scale;
  logic           en;
  logic           fv, sv;
  front_t         fd;
  div_t           sd;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale <= cfg_data;
    end
  end

  tws_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .poll_sent      (poll_sent),
    .poll_received  (poll_received),
    .reply_sent     (reply_sent),
    .reply_received (reply_received),
    .final_sent     (final_sent),
    .final_received (final_received),
    .scale          (scale),
    .out_valid      (fv),
    .out_data       (fd)
  );

  tws_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv),
    .in_data   (fd),
    .scale     (scale),
    .out_valid (sv),
    .out_data  (sd)
  );

  tws_div u_div (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (sv),
    .in_data          (sd),
    .out_valid        (out_valid),
    .final_gap        (final_gap),
    .single_range_mm  (single_range_mm),
    .two_way_range_mm (two_way_range_mm),
    .divide_fault     (divide_fault)
  );

endmodule
